/* design/bcdc_pkg.sv */
// Package for the packed BCD / binary converter.
// Holds the beat types, width constants and the small arithmetic helpers.
// No dependencies.
package bcdc_pkg;

    localparam int PAIR_COUNT = 4;
    localparam int PAIR_W     = 7;
    localparam int VALUE_W    = 27;
    localparam int WORD_W     = 32;
    localparam int RECIP_W    = 29;
    localparam int RECIP_SHIFT = 34;

    localparam logic [VALUE_W-1:0] DEC_LIMIT = 27'd100000000;
    localparam logic [RECIP_W-1:0] RECIP_100 = 29'd171798692;

    typedef enum logic
    {
        OP_DECODE = 1'b0,
        OP_ENCODE = 1'b1
    } bcdc_op_t;

    typedef struct packed
    {
        bcdc_op_t            op;
        logic [WORD_W-1:0]   bcd_word;
        logic [VALUE_W-1:0]  binary_value;
    } bcdc_in_t;

    typedef struct packed
    {
        logic [VALUE_W-1:0]  result_value;
        logic [WORD_W-1:0]   result_bcd;
        logic                digits_valid;
    } bcdc_out_t;

    typedef logic [PAIR_W-1:0] bcdc_pair_t;

    typedef struct packed
    {
        bcdc_op_t                         op;
        logic                             ok;
        logic                             big_endian;
        logic [VALUE_W-1:0]               acc;
        bcdc_pair_t [PAIR_COUNT-1:0]      pairs;
    } bcdc_beat_t;

    function automatic logic [VALUE_W-1:0] times100(input logic [VALUE_W-1:0] x);
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

    function automatic bcdc_pair_t nibbles_to_pair(input logic [3:0] hi, input logic [3:0] lo);
        logic [PAIR_W-1:0] h;
        h = {3'b000, hi};
        return (h << 3) + (h << 1) + {3'b000, lo};
    endfunction

    function automatic logic [7:0] pair_to_bcd(input bcdc_pair_t p);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [PAIR_W-1:0] ones;
        prod = {7'd0, p} * 14'd103;
        tens = prod[13:10];
        ones = p - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
        return {tens, ones[3:0]};
    endfunction

endpackage

/* design/bcdc_prep.sv */
// Input stage of the converter: digit checks, digit pair values, range reduction.
// Depends on bcdc_pkg.
module bcdc_prep
    import bcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  bcdc_in_t    cmd,
    input  logic        big_endian,
    output logic        out_vld,
    output bcdc_beat_t  out_beat
);

    logic       vld_reg;
    bcdc_beat_t beat_reg;
    bcdc_beat_t beat_next;

    always_comb
    begin
        logic [7:0] byte_k;
        logic       ok;
        beat_next            = '0;
        beat_next.op         = cmd.op;
        beat_next.big_endian = big_endian;
        ok = 1'b1;
        for (int k = 0; k < PAIR_COUNT; k++)
        begin
            byte_k = cmd.bcd_word[8*k +: 8];
            if (byte_k[7:4] > 4'd9 || byte_k[3:0] > 4'd9)
            begin
                ok = 1'b0;
            end
            if (big_endian)
            begin
                beat_next.pairs[k] = nibbles_to_pair(byte_k[7:4], byte_k[3:0]);
            end
            else
            begin
                beat_next.pairs[PAIR_COUNT-1-k] = nibbles_to_pair(byte_k[7:4], byte_k[3:0]);
            end
        end
        if (cmd.op == OP_ENCODE)
        begin
            beat_next.ok    = 1'b1;
            beat_next.pairs = '0;
            if (cmd.binary_value >= DEC_LIMIT)
            begin
                beat_next.acc = cmd.binary_value - DEC_LIMIT;
            end
            else
            begin
                beat_next.acc = cmd.binary_value;
            end
        end
        else
        begin
            beat_next.ok  = ok;
            beat_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_vld  = vld_reg;
    assign out_beat = beat_reg;

endmodule

/* design/bcdc_cell.sv */
// One digit pair cell: a Horner step for decode, a divide by 100 for encode.
// Depends on bcdc_pkg.
module bcdc_cell
    import bcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  bcdc_beat_t  in_beat,
    output logic        out_vld,
    output bcdc_beat_t  out_beat
);

    logic       vld_reg;
    bcdc_beat_t beat_reg;
    bcdc_beat_t beat_next;

    always_comb
    begin
        logic [VALUE_W+RECIP_W-1:0] prod;
        logic [VALUE_W-1:0]         quot;
        logic [VALUE_W-1:0]         rem;
        prod = {{RECIP_W{1'b0}}, in_beat.acc} * {{VALUE_W{1'b0}}, RECIP_100};
        quot = {{(RECIP_SHIFT-RECIP_W){1'b0}}, prod[VALUE_W+RECIP_W-1:RECIP_SHIFT]};
        rem  = in_beat.acc - times100(quot);
        beat_next = in_beat;
        for (int i = 0; i < PAIR_COUNT-1; i++)
        begin
            beat_next.pairs[i] = in_beat.pairs[i+1];
        end
        if (in_beat.op == OP_ENCODE)
        begin
            beat_next.acc               = quot;
            beat_next.pairs[PAIR_COUNT-1] = rem[PAIR_W-1:0];
        end
        else
        begin
            beat_next.acc = times100(in_beat.acc)
                          + {{(VALUE_W-PAIR_W){1'b0}}, in_beat.pairs[0]};
            beat_next.pairs[PAIR_COUNT-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_vld  = vld_reg;
    assign out_beat = beat_reg;

endmodule

/* design/bcdc_pack.sv */
// Output stage of the converter: packs digit pairs into BCD bytes and forms the result.
// Depends on bcdc_pkg.
module bcdc_pack
    import bcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  bcdc_beat_t  in_beat,
    output logic        done,
    output bcdc_out_t   result
);

    logic      done_reg;
    bcdc_out_t result_reg;
    bcdc_out_t result_next;

    always_comb
    begin
        result_next = '0;
        if (in_beat.op == OP_ENCODE)
        begin
            result_next.digits_valid = 1'b1;
            for (int k = 0; k < PAIR_COUNT; k++)
            begin
                if (in_beat.big_endian)
                begin
                    result_next.result_bcd[8*k +: 8] =
                        pair_to_bcd(in_beat.pairs[PAIR_COUNT-1-k]);
                end
                else
                begin
                    result_next.result_bcd[8*k +: 8] = pair_to_bcd(in_beat.pairs[k]);
                end
            end
        end
        else
        begin
            result_next.digits_valid = in_beat.ok;
            result_next.result_value = in_beat.ok ? in_beat.acc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/packed_bcd_binary_converter.sv */
// Top level of the packed BCD / binary converter: input stage, four pair cells, output stage.
// Depends on bcdc_pkg, bcdc_prep, bcdc_cell and bcdc_pack.
//
// Usage:
// A command beat (cmd) is taken at a rising edge where start is high and busy is low.
// busy is always low, so a new beat may be issued in every cycle.
// cmd.op selects decode of cmd.bcd_word or encode of cmd.binary_value.
// Each command gives exactly one result beat on result, marked by done for one cycle.
// done and the result come from the output register, after the beat has passed these registers in order:
// the input stage registers at the accepting edge, then one cell per digit pair (four)
// and one output register follow. Throughput is one beat per cycle.
// The receiver cannot stall; results are never held.
// cfg_wr_en writes cfg_wr_data into the byte order register at a clock edge.
// Reset sets the order to most significant pair in byte 0 and empties the pipeline.
module packed_bcd_binary_converter
    import bcdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  bcdc_in_t   cmd,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    output logic       done,
    output bcdc_out_t  result
);

    logic                       big_endian_reg;
    logic       [PAIR_COUNT:0]  chain_vld;
    bcdc_beat_t [PAIR_COUNT:0]  chain_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            big_endian_reg <= cfg_wr_data;
        end
    end

    assign busy = 1'b0;

    bcdc_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (start & ~busy),
        .cmd        (cmd),
        .big_endian (big_endian_reg),
        .out_vld    (chain_vld[0]),
        .out_beat   (chain_beat[0])
    );

    for (genvar g = 0; g < PAIR_COUNT; g++)
    begin : g_cell
        bcdc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (chain_vld[g]),
            .in_beat  (chain_beat[g]),
            .out_vld  (chain_vld[g+1]),
            .out_beat (chain_beat[g+1])
        );
    end

    bcdc_pack u_pack
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (chain_vld[PAIR_COUNT]),
        .in_beat (chain_beat[PAIR_COUNT]),
        .done    (done),
        .result  (result)
    );

endmodule
